[rtl/core/icmp_receive_classifier_macros.svh]
// Assertion macros used by the ICMP receive classifier checker.
`ifndef ICMP_RECEIVE_CLASSIFIER_MACROS_SVH
`define ICMP_RECEIVE_CLASSIFIER_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ICMP_RC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("icmp receive classifier assertion failed");

// Property checked on every clock edge, reset included.
`define ICMP_RC_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("icmp receive classifier assertion failed");

`endif

[rtl/core/icmp_rc_pkg.sv]
// Types and constants of the ICMP receive classifier.
package icmp_rc_pkg;

  localparam int unsigned WORD_W     = 16;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned TTL_W      = 8;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned MATCH_W    = 16;
  localparam int unsigned IN_TDATA_W = 56;
  localparam int unsigned OUT_TDATA_W = 128;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned NUM_KINDS   = 6;
  localparam int unsigned KIND_IDX_W  = 3;

  localparam logic [WORD_W-1:0]  ONES16     = 16'hFFFF;
  localparam logic [WORD_W-1:0]  HEADER_LEN = 16'd8;
  localparam logic [BYTE_W-1:0]  ICMP_ECHO_REPLY    = 8'd0;
  localparam logic [BYTE_W-1:0]  ICMP_UNREACHABLE   = 8'd3;
  localparam logic [BYTE_W-1:0]  ICMP_ECHO_REQUEST  = 8'd8;
  localparam logic [BYTE_W-1:0]  ICMP_TIME_EXCEEDED = 8'd11;
  localparam logic [BYTE_W-1:0]  CODE_NET_UNREACH  = 8'd0;
  localparam logic [BYTE_W-1:0]  CODE_HOST_UNREACH = 8'd1;
  localparam logic [KIND_IDX_W-1:0] REJECT_COUNTER = 3'd5;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SESSION_ACTIVE = 2'd0,
    REG_TARGET_ADDRESS = 2'd1,
    REG_SESSION_IDENT  = 2'd2,
    REG_SESSION_SEQNO  = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    VERDICT_OK      = 2'd0,
    VERDICT_SHORT   = 2'd1,
    VERDICT_BAD_SUM = 2'd2
  } verdict_t;

  typedef enum logic [2:0] {
    KIND_ECHO_REQUEST = 3'd0,
    KIND_ECHO_REPLY   = 3'd1,
    KIND_UNREACHABLE  = 3'd2,
    KIND_TIME_EXCEEDED = 3'd3,
    KIND_OTHER        = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    OUTCOME_NONE          = 3'd0,
    OUTCOME_SUCCESS       = 3'd1,
    OUTCOME_DEST_UNREACH  = 3'd2,
    OUTCOME_HOST_UNREACH  = 3'd3,
    OUTCOME_NET_UNREACH   = 3'd4,
    OUTCOME_TTL_EXCEEDED  = 3'd5
  } outcome_t;

  // Result item, last field (verdict) in the lowest bits.
  typedef struct packed {
    logic [6:0]         pad;
    logic [MATCH_W-1:0] session_replies;
    logic [TTL_W-1:0]   sender_ttl;
    logic [ADDR_W-1:0]  sender_address;
    logic [WORD_W-1:0]  payload_bytes;
    logic [WORD_W-1:0]  echo_seq;
    logic [WORD_W-1:0]  echo_ident;
    logic [BYTE_W-1:0]  msg_code;
    outcome_t           ping_outcome;
    logic               reply_due;
    kind_t              msg_kind;
    verdict_t           verdict;
  } result_t;

endpackage

[rtl/core/icmp_receive_classifier.sv]
// ICMP receive classifier: checksum, header capture and per-message verdict.
// The result of a message is registered in out_r when its last item leaves the input register.
// Throughput: one item per cycle; a last item waits in the input register while a result stalls.
// A message's running sum and header fields live in one register set updated per item.
// Reset (rst_n low, synchronous) clears session settings, message state and counters.
module icmp_receive_classifier (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [icmp_rc_pkg::IN_TDATA_W-1:0]   in_tdata,  // msg_word, source_address, hop_limit
  input  logic                                 in_tlast,
  input  logic                                 in_tuser,  // odd_final
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // verdict, msg_kind, reply_due, ping_outcome, msg_code, echo_ident, echo_seq,
  // payload_bytes, sender_address, sender_ttl, session_replies, zero fill
  output logic [icmp_rc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [icmp_rc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [icmp_rc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import icmp_rc_pkg::*;

  logic                session_active_r;
  logic [ADDR_W-1:0]   target_address_r;
  logic [WORD_W-1:0]   session_ident_r;
  logic [WORD_W-1:0]   session_seqno_r;

  logic                s1_valid_r;
  logic [WORD_W-1:0]   s1_word_r;
  logic                s1_last_r;
  logic                s1_odd_r;
  logic [ADDR_W-1:0]   s1_src_r;
  logic [TTL_W-1:0]    s1_ttl_r;

  logic [WORD_W-1:0]   running_sum_r, running_sum_nxt;
  logic [WORD_W-1:0]   byte_count_r, byte_count_nxt;
  logic [BYTE_W-1:0]   header_type_r, header_type_nxt;
  logic [BYTE_W-1:0]   header_code_r, header_code_nxt;
  logic [WORD_W-1:0]   header_ident_r, header_ident_nxt;
  logic [WORD_W-1:0]   header_seq_r, header_seq_nxt;
  logic [MATCH_W-1:0]  matched_count_r, matched_count_nxt;
  logic [COUNT_W-1:0]  kind_counters_r [NUM_KINDS];

  logic                out_valid_r;
  result_t             out_r, result_nxt;

  logic                s1_adv;
  logic                odd;
  logic [WORD_W-1:0]   word_m;
  logic [WORD_W:0]     sum_wide;
  logic [WORD_W:0]     count_wide;
  logic [WORD_W-2:0]   widx;
  logic                match;
  logic [KIND_IDX_W-1:0] cnt_idx;

  assign cfg_ready  = 1'b1;
  assign s1_adv     = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || s1_adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

  always_comb begin
    odd        = s1_last_r && s1_odd_r;
    word_m     = odd ? {s1_word_r[WORD_W-1:BYTE_W], {BYTE_W{1'b0}}} : s1_word_r;
    sum_wide   = {1'b0, running_sum_r} + {1'b0, word_m};
    running_sum_nxt = sum_wide[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, sum_wide[WORD_W]};
    count_wide = {1'b0, byte_count_r} + (odd ? 17'd1 : 17'd2);
    byte_count_nxt = count_wide[WORD_W] ? ONES16 : count_wide[WORD_W-1:0];
    widx       = byte_count_r[WORD_W-1:1];

    header_type_nxt  = header_type_r;
    header_code_nxt  = header_code_r;
    header_ident_nxt = header_ident_r;
    header_seq_nxt   = header_seq_r;
    case (widx)
      15'd0: begin
        header_type_nxt = word_m[WORD_W-1:BYTE_W];
        header_code_nxt = word_m[BYTE_W-1:0];
      end
      15'd2: header_ident_nxt = word_m;
      15'd3: header_seq_nxt   = word_m;
      default: ;
    endcase

    match = session_active_r && (s1_src_r == target_address_r) &&
            (header_ident_nxt == session_ident_r) && (header_seq_nxt == session_seqno_r);

    matched_count_nxt           = matched_count_r;
    result_nxt                  = '0;
    result_nxt.verdict          = VERDICT_OK;
    result_nxt.msg_kind         = KIND_OTHER;
    result_nxt.ping_outcome     = OUTCOME_NONE;
    result_nxt.sender_address   = s1_src_r;
    result_nxt.sender_ttl       = s1_ttl_r;
    cnt_idx                     = REJECT_COUNTER;

    if (byte_count_nxt < HEADER_LEN) begin
      result_nxt.verdict = VERDICT_SHORT;
    end else if (running_sum_nxt != ONES16) begin
      result_nxt.verdict = VERDICT_BAD_SUM;
    end else begin
      result_nxt.msg_code      = header_code_nxt;
      result_nxt.echo_ident    = header_ident_nxt;
      result_nxt.echo_seq      = header_seq_nxt;
      result_nxt.payload_bytes = byte_count_nxt - HEADER_LEN;
      case (header_type_nxt)
        ICMP_ECHO_REQUEST: begin
          result_nxt.msg_kind  = KIND_ECHO_REQUEST;
          result_nxt.reply_due = 1'b1;
        end
        ICMP_ECHO_REPLY: begin
          result_nxt.msg_kind = KIND_ECHO_REPLY;
          if (match) begin
            result_nxt.ping_outcome = OUTCOME_SUCCESS;
            if (matched_count_r != {MATCH_W{1'b1}}) begin
              matched_count_nxt = matched_count_r + MATCH_W'(1);
            end
          end
        end
        ICMP_UNREACHABLE: begin
          result_nxt.msg_kind = KIND_UNREACHABLE;
          if (session_active_r) begin
            if (header_code_nxt == CODE_HOST_UNREACH) begin
              result_nxt.ping_outcome = OUTCOME_HOST_UNREACH;
            end else if (header_code_nxt == CODE_NET_UNREACH) begin
              result_nxt.ping_outcome = OUTCOME_NET_UNREACH;
            end else begin
              result_nxt.ping_outcome = OUTCOME_DEST_UNREACH;
            end
          end
        end
        ICMP_TIME_EXCEEDED: begin
          result_nxt.msg_kind = KIND_TIME_EXCEEDED;
          if (session_active_r) begin
            result_nxt.ping_outcome = OUTCOME_TTL_EXCEEDED;
          end
        end
        default: result_nxt.msg_kind = KIND_OTHER;
      endcase
      cnt_idx = {1'b0, result_nxt.msg_kind[1:0]} | {result_nxt.msg_kind[2], 2'b00};
    end
    result_nxt.session_replies = matched_count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      session_active_r <= 1'b0;
      target_address_r <= '0;
      session_ident_r  <= '0;
      session_seqno_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_SESSION_ACTIVE: session_active_r <= cfg_data[0];
        REG_TARGET_ADDRESS: target_address_r <= cfg_data;
        REG_SESSION_IDENT:  session_ident_r  <= cfg_data[WORD_W-1:0];
        REG_SESSION_SEQNO:  session_seqno_r  <= cfg_data[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      s1_word_r <= in_tdata[WORD_W-1:0];
      s1_src_r  <= in_tdata[WORD_W+ADDR_W-1:WORD_W];
      s1_ttl_r  <= in_tdata[IN_TDATA_W-1:WORD_W+ADDR_W];
      s1_last_r <= in_tlast;
      s1_odd_r  <= in_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_sum_r   <= '0;
      byte_count_r    <= '0;
      header_type_r   <= '0;
      header_code_r   <= '0;
      header_ident_r  <= '0;
      header_seq_r    <= '0;
      matched_count_r <= '0;
      for (int i = 0; i < NUM_KINDS; i++) begin
        kind_counters_r[i] <= '0;
      end
    end else if (s1_adv) begin
      if (s1_last_r) begin
        running_sum_r   <= '0;
        byte_count_r    <= '0;
        header_type_r   <= '0;
        header_code_r   <= '0;
        header_ident_r  <= '0;
        header_seq_r    <= '0;
        matched_count_r <= matched_count_nxt;
        if (kind_counters_r[cnt_idx] != {COUNT_W{1'b1}}) begin
          kind_counters_r[cnt_idx] <= kind_counters_r[cnt_idx] + COUNT_W'(1);
        end
      end else begin
        running_sum_r  <= running_sum_nxt;
        byte_count_r   <= byte_count_nxt;
        header_type_r  <= header_type_nxt;
        header_code_r  <= header_code_nxt;
        header_ident_r <= header_ident_nxt;
        header_seq_r   <= header_seq_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_adv && s1_last_r) begin
      out_r <= result_nxt;
    end
  end

endmodule

[rtl/core/icmp_rc_checker.sv]
// Port-level checker for the ICMP receive classifier, with its bind.
`include "icmp_receive_classifier_macros.svh"

module icmp_rc_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [icmp_rc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import icmp_rc_pkg::*;

  result_t res;
  assign res = out_tdata;

  // A stalled result keeps its contents.
  `ICMP_RC_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))

  // A rejected message carries no header contents.
  `ICMP_RC_ASSERT(a_reject_clean, out_tvalid && res.verdict != VERDICT_OK |-> res.msg_kind == KIND_OTHER && res.payload_bytes == '0 && res.ping_outcome == OUTCOME_NONE && !res.reply_due)

  // A reply is due only for an accepted echo request.
  `ICMP_RC_ASSERT(a_reply_due, out_tvalid && res.reply_due |-> res.verdict == VERDICT_OK && res.msg_kind == KIND_ECHO_REQUEST)

  // No result is offered in the cycle after reset.
  `ICMP_RC_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_tvalid)

endmodule

bind icmp_receive_classifier icmp_rc_checker u_icmp_rc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[test/icmp_receive_classifier_tb.sv]
// Self-checking testbench for the ICMP receive classifier: message streams against a predictor.
module icmp_receive_classifier_tb;
  import icmp_rc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned REPORT_LIMIT = 100;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;  // msg_word, source_address, hop_limit
  logic                   in_tlast   = 1'b0;
  logic                   in_tuser   = 1'b0;  // odd_final
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  icmp_receive_classifier i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  int unsigned idle_pct    = 0;
  int unsigned stall_pct   = 0;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned items_sent  = 0;

  // Session settings as the block should hold them.
  bit        sess_active;
  bit [31:0] sess_target;
  bit [15:0] sess_ident;
  bit [15:0] sess_seqno;

  // Per-message state and the matched reply count.
  bit [15:0] sum_acc;
  bit [15:0] byte_total;
  bit [7:0]  hdr_type;
  bit [7:0]  hdr_code;
  bit [15:0] hdr_ident;
  bit [15:0] hdr_seq;
  bit [15:0] reply_matches;

  result_t   pending_verdicts[$];
  bit [15:0] msg_words[$];
  bit        msg_odd;

  function automatic void classify_item(bit [15:0] word_in, bit last, bit tuser,
                                        bit [31:0] src, bit [7:0] ttl);
    bit        odd;
    bit [15:0] word;
    bit [16:0] acc;
    bit [16:0] cnt;
    result_t   r;
    odd  = last && tuser;
    word = odd ? {word_in[15:8], 8'h00} : word_in;
    acc  = {1'b0, sum_acc} + {1'b0, word};
    sum_acc = acc[16] ? acc[15:0] + 16'd1 : acc[15:0];
    case (byte_total[15:1])
      15'd0: begin
        hdr_type = word[15:8];
        hdr_code = word[7:0];
      end
      15'd2: hdr_ident = word;
      15'd3: hdr_seq = word;
      default: ;
    endcase
    cnt = {1'b0, byte_total} + (odd ? 17'd1 : 17'd2);
    byte_total = cnt[16] ? ONES16 : cnt[15:0];
    if (last) begin
      r = '0;
      r.msg_kind       = KIND_OTHER;
      r.ping_outcome   = OUTCOME_NONE;
      r.sender_address = src;
      r.sender_ttl     = ttl;
      if (byte_total < HEADER_LEN) begin
        r.verdict = VERDICT_SHORT;
      end else if (sum_acc != ONES16) begin
        r.verdict = VERDICT_BAD_SUM;
      end else begin
        r.verdict       = VERDICT_OK;
        r.msg_code      = hdr_code;
        r.echo_ident    = hdr_ident;
        r.echo_seq      = hdr_seq;
        r.payload_bytes = byte_total - HEADER_LEN;
        if (hdr_type == ICMP_ECHO_REQUEST) begin
          r.msg_kind  = KIND_ECHO_REQUEST;
          r.reply_due = 1'b1;
        end else if (hdr_type == ICMP_ECHO_REPLY) begin
          r.msg_kind = KIND_ECHO_REPLY;
          if (sess_active && src == sess_target && hdr_ident == sess_ident &&
              hdr_seq == sess_seqno) begin
            r.ping_outcome = OUTCOME_SUCCESS;
            if (reply_matches != ONES16) reply_matches++;
          end
        end else if (hdr_type == ICMP_UNREACHABLE) begin
          r.msg_kind = KIND_UNREACHABLE;
          if (sess_active) begin
            if (hdr_code == CODE_HOST_UNREACH) r.ping_outcome = OUTCOME_HOST_UNREACH;
            else if (hdr_code == CODE_NET_UNREACH) r.ping_outcome = OUTCOME_NET_UNREACH;
            else r.ping_outcome = OUTCOME_DEST_UNREACH;
          end
        end else if (hdr_type == ICMP_TIME_EXCEEDED) begin
          r.msg_kind = KIND_TIME_EXCEEDED;
          if (sess_active) r.ping_outcome = OUTCOME_TTL_EXCEEDED;
        end
      end
      r.session_replies = reply_matches;
      pending_verdicts.push_back(r);
      sum_acc    = '0;
      byte_total = '0;
      hdr_type   = '0;
      hdr_code   = '0;
      hdr_ident  = '0;
      hdr_seq    = '0;
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      error_count++;
      if (error_count <= REPORT_LIMIT)
        $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_results
    result_t want;
    result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = result_t'(out_tdata);
      if (pending_verdicts.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT) $error("result item arrived with none expected");
      end else begin
        want = pending_verdicts.pop_front();
        check_field("verdict", want.verdict, got.verdict);
        check_field("msg_kind", want.msg_kind, got.msg_kind);
        check_field("reply_due", want.reply_due, got.reply_due);
        check_field("ping_outcome", want.ping_outcome, got.ping_outcome);
        check_field("msg_code", want.msg_code, got.msg_code);
        check_field("echo_ident", want.echo_ident, got.echo_ident);
        check_field("echo_seq", want.echo_seq, got.echo_seq);
        check_field("payload_bytes", want.payload_bytes, got.payload_bytes);
        check_field("sender_address", want.sender_address, got.sender_address);
        check_field("sender_ttl", want.sender_ttl, got.sender_ttl);
        check_field("session_replies", want.session_replies, got.session_replies);
        check_field("zero_fill", want.pad, got.pad);
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("icmp_receive_classifier_tb: FAIL");
    $finish;
  end

  task automatic send_item(bit [15:0] word, bit last, bit tuser, bit [31:0] src, bit [7:0] ttl);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= {ttl, src, word};
    in_tlast  <= last;
    in_tuser  <= tuser;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    classify_item(word, last, tuser, src, ttl);
    items_sent++;
  endtask

  // Lays out a message whose checksum word makes it sum to all ones unless corrupt is set.
  function automatic void build_message(bit [7:0] typ, bit [7:0] code, bit [15:0] ident,
                                        bit [15:0] seq, int unsigned payload_len, bit corrupt);
    int unsigned       total;
    int unsigned       nwords;
    longint unsigned   acc;
    total  = 8 + payload_len;
    nwords = (total + 1) / 2;
    msg_odd = 1'(total % 2);
    msg_words.delete();
    msg_words.push_back({typ, code});
    msg_words.push_back(16'h0000);
    msg_words.push_back(ident);
    msg_words.push_back(seq);
    while (msg_words.size() < nwords) msg_words.push_back(16'($urandom));
    acc = 0;
    foreach (msg_words[i]) begin
      if (msg_odd && i == nwords - 1) acc += {msg_words[i][15:8], 8'h00};
      else acc += msg_words[i];
    end
    msg_words[1] = ONES16 - 16'(acc % 65535);
    if (corrupt) msg_words[1] = msg_words[1] ^ 16'(1 << $urandom_range(0, 15));
  endfunction

  function automatic void build_raw(int unsigned nbytes);
    msg_words.delete();
    repeat ((nbytes + 1) / 2) msg_words.push_back(16'($urandom));
    msg_odd = 1'(nbytes % 2);
  endfunction

  task automatic send_message(bit [31:0] src, bit [7:0] ttl, bit noisy);
    bit last;
    foreach (msg_words[i]) begin
      last = (i == msg_words.size() - 1);
      if (last) send_item(msg_words[i], 1'b1, msg_odd, src, ttl);
      else if (noisy) send_item(msg_words[i], 1'b0, 1'($urandom), $urandom, 8'($urandom));
      else send_item(msg_words[i], 1'b0, 1'($urandom), src, ttl);
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, bit [31:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SESSION_ACTIVE: sess_active = value[0];
      REG_TARGET_ADDRESS: sess_target = value;
      REG_SESSION_IDENT:  sess_ident  = value[15:0];
      REG_SESSION_SEQNO:  sess_seqno  = value[15:0];
      default: ;
    endcase
  endtask

  task automatic set_session(bit active, bit [31:0] target, bit [15:0] ident, bit [15:0] seq);
    wait_idle();
    write_reg(REG_SESSION_ACTIVE, {31'($urandom), active});
    write_reg(REG_TARGET_ADDRESS, target);
    write_reg(REG_SESSION_IDENT, {16'($urandom), ident});
    write_reg(REG_SESSION_SEQNO, {16'($urandom), seq});
    cfg_valid <= 1'b0;
  endtask

  task automatic random_message();
    int unsigned pick;
    int unsigned len;
    int unsigned flip;
    bit [7:0]    typ;
    bit [7:0]    code;
    bit [15:0]   ident;
    bit [15:0]   seq;
    bit [31:0]   src;
    pick  = $urandom_range(0, 99);
    flip  = $urandom_range(0, 31);
    src   = $urandom;
    ident = 16'($urandom);
    seq   = 16'($urandom);
    code  = $urandom_range(0, 1) ? 8'h00 : 8'($urandom);
    if (pick < 78) begin
      case ($urandom_range(0, 9))
        0, 1, 2: typ = ICMP_ECHO_REQUEST;
        3, 4, 5: begin
          typ = ICMP_ECHO_REPLY;
          if ($urandom_range(0, 1)) begin
            src   = sess_target;
            ident = sess_ident;
            seq   = sess_seqno;
            case ($urandom_range(0, 5))
              0: src[flip] = ~src[flip];
              1: ident[flip % 16] = ~ident[flip % 16];
              2: seq[flip % 16] = ~seq[flip % 16];
              default: ;
            endcase
          end
        end
        6, 7: begin
          typ = ICMP_UNREACHABLE;
          case ($urandom_range(0, 2))
            0: code = CODE_NET_UNREACH;
            1: code = CODE_HOST_UNREACH;
            default: code = 8'($urandom_range(2, 255));
          endcase
        end
        8: typ = ICMP_TIME_EXCEEDED;
        default: typ = 8'($urandom);
      endcase
      if (typ != ICMP_ECHO_REPLY && $urandom_range(0, 3) == 0) src = sess_target;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 120) : $urandom_range(0, 16);
      build_message(typ, code, ident, seq, len, $urandom_range(0, 9) == 0);
      send_message(src, 8'($urandom), 1'b0);
    end else if (pick < 88) begin
      build_raw($urandom_range(1, 7));
      send_message(src, 8'($urandom), 1'b0);
    end else begin
      build_raw($urandom_range(1, 14));
      msg_odd = 1'($urandom);
      send_message(src, 8'($urandom), 1'b1);
    end
  endtask

  task automatic test_directed();
    idle_pct  = 0;
    stall_pct = 0;
    build_raw(1);
    send_message(32'hFFFF_FFFF, 8'h00, 1'b0);
    msg_words = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
    msg_odd   = 1'b0;
    send_message(32'h0000_0000, 8'hFF, 1'b0);
    build_message(ICMP_ECHO_REQUEST, 8'hFF, 16'hFFFF, 16'h0000, 1, 1'b0);
    send_message(32'h0000_0000, 8'hFF, 1'b0);
    set_session(1'b1, 32'hC0A8_0101, 16'h1234, 16'hABCD);
    build_message(ICMP_ECHO_REPLY, 8'h00, 16'h1234, 16'hABCD, 0, 1'b0);
    send_message(32'hC0A8_0101, 8'd64, 1'b0);
    build_message(ICMP_UNREACHABLE, CODE_NET_UNREACH, 16'($urandom), 16'($urandom), 0, 1'b0);
    send_message($urandom, 8'($urandom), 1'b0);
    build_message(ICMP_UNREACHABLE, CODE_HOST_UNREACH, 16'($urandom), 16'($urandom), 0, 1'b0);
    send_message($urandom, 8'($urandom), 1'b0);
    build_message(ICMP_TIME_EXCEEDED, 8'h00, 16'($urandom), 16'($urandom), 0, 1'b0);
    send_message($urandom, 8'($urandom), 1'b0);
  endtask

  task automatic test_random(int unsigned idle, int unsigned stall, bit active,
                             bit [31:0] target, bit [15:0] ident, bit [15:0] seq,
                             int unsigned count);
    int unsigned start;
    set_session(active, target, ident, seq);
    idle_pct  = idle;
    stall_pct = stall;
    start = items_sent;
    while (items_sent - start < count) random_message();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(0, 0, 1'b1, 32'h0000_0000, 16'h0000, 16'h0000, 360);
    test_random(66, 0, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 360);
    test_random(0, 66, 1'b0, $urandom, 16'($urandom), 16'($urandom), 360);
    test_random(23, 23, 1'b1, $urandom, 16'($urandom), 16'($urandom), 370);
    wait_idle();
    if (error_count == 0) begin
      $display("icmp_receive_classifier_tb: PASS");
    end else begin
      $display("icmp_receive_classifier_tb: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/icmp_rc_pkg.sv
rtl/core/icmp_receive_classifier.sv
rtl/core/icmp_rc_checker.sv
test/icmp_receive_classifier_tb.sv
